// ===== rtl/cpd_pkg.sv =====
package cpd_pkg;

    localparam int unsigned MV_W           = 15;
    localparam int unsigned CFG_IDX_W      = 3;
    localparam int unsigned WINDOW_LEN_DEF = 10;

    typedef logic [MV_W-1:0] t_mv;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEWER_BOARD = 3'd0,
        CFG_RISE_MV     = 3'd1,
        CFG_FALL_MV     = 3'd2,
        CFG_CHARGE_MIN  = 3'd3,
        CFG_SYS_LOAD    = 3'd4,
        CFG_VOLT_STEP   = 3'd5,
        CFG_SPREAD_MAX  = 3'd6
    } t_cfg_idx;

    localparam logic RST_NEWER_BOARD = 1'b1;
    localparam t_mv  RST_RISE_MV     = 15'd70;
    localparam t_mv  RST_FALL_MV     = 15'd50;
    localparam t_mv  RST_CHARGE_MIN  = 15'd150;
    localparam t_mv  RST_SYS_LOAD    = 15'd2000;
    localparam t_mv  RST_VOLT_STEP   = 15'd150;
    localparam t_mv  RST_SPREAD_MAX  = 15'd1000;

    typedef struct packed {
        logic charging;
        logic plugged;
        logic unplug;
        logic hotplug;
    } t_flags;

endpackage

// ===== rtl/cpd_if.sv =====
interface cpd_in_if;
    import cpd_pkg::*;
    logic valid;
    logic ready;
    logic charger_present;
    t_mv  battery_mv;
    t_mv  system_ma;
    t_mv  charge_ma;
    modport source (output valid, charger_present, battery_mv, system_ma, charge_ma,
                    input ready);
    modport sink   (input valid, charger_present, battery_mv, system_ma, charge_ma,
                    output ready);
endinterface

interface cpd_out_if;
    logic valid;
    logic ready;
    logic is_charging;
    logic charger_plugged;
    logic unplug_detected;
    logic hotplug_armed;
    modport source (output valid, is_charging, charger_plugged, unplug_detected,
                    hotplug_armed, input ready);
    modport sink   (input valid, is_charging, charger_plugged, unplug_detected,
                    hotplug_armed, output ready);
endinterface

interface cpd_cfg_if;
    import cpd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] addr;
    t_mv                  data;
    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// ===== rtl/cpd_ram.sv =====
module cpd_ram #(
    parameter int unsigned WIDTH = 15,
    parameter int unsigned DEPTH = 10
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/cpd_cmp.sv =====
module cpd_cmp (
    input  cpd_pkg::t_mv i_a,
    input  cpd_pkg::t_mv i_b,
    output logic         o_gt,
    output cpd_pkg::t_mv o_diff
);
    import cpd_pkg::*;

    logic [MV_W:0] sub;

    // one subtractor gives the ordering test, a second one gives the spread
    assign sub    = {1'b0, i_b} - {1'b0, i_a};
    assign o_gt   = sub[MV_W];
    assign o_diff = i_a - i_b;
endmodule

// ===== rtl/charger_presence_detector.sv =====
// channel  | direction | transfer carries
// ---------+-----------+----------------------------------------------------------
// i_in     | in        | charger_present, battery_mv, system_ma, charge_ma
// o_out    | out       | is_charging, charger_plugged, unplug_detected, hotplug_armed
// i_cfg    | in        | addr (register index), data; always ready
//
// a sample runs eval, finish and emit (a low pin runs eval and emit); when the window
// closes, the trend check runs after eval: one compare/subtract unit walks the stored
// currents, one ram read and two compares per entry, then the trend step.
// i_in.ready is high only in idle; a result waits in the output register while the
// next sample is taken, and a finished sample waits for that register to empty.
// i_rst_n is synchronous, active low; state, flags, reference, fill and configuration go to reset.
module charger_presence_detector #(
    parameter int unsigned WINDOW_LEN = cpd_pkg::WINDOW_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cpd_in_if.sink      i_in,
    cpd_out_if.source   o_out,
    cpd_cfg_if.sink     i_cfg
);
    import cpd_pkg::*;

    localparam int unsigned AW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam logic [AW-1:0] LAST      = AW'(WINDOW_LEN - 1);
    localparam logic [AW-1:0] LAST_WALK = AW'(WINDOW_LEN - 2);

    typedef enum logic [2:0] {
        S_IDLE, S_EVAL, S_READ, S_MAX, S_MIN, S_TREND, S_FINISH, S_EMIT
    } t_state;

    // configuration
    logic r_newer;
    t_mv  r_rise_mv, r_fall_mv, r_chg_min, r_sys_load, r_step, r_spread;

    // sample
    logic r_pin;
    t_mv  r_v, r_s, r_c;

    t_state         r_state, n_state;
    logic           r_charging, n_charging;
    logic           r_plugged, n_plugged;
    logic           r_unplug, n_unplug;
    logic           r_hotplug, n_hotplug;
    t_mv            r_ref, n_ref;
    t_mv            r_volt0, n_volt0;
    logic [AW-1:0]  r_fill, n_fill;
    logic           r_wrap, n_wrap;
    logic [AW-1:0]  r_idx, n_idx;
    t_mv            r_mx, n_mx;
    t_mv            r_mn, n_mn;
    logic           r_out_valid, n_out_valid;
    t_flags         r_out;

    logic           in_acc, out_load;
    logic           ram_we, ram_re;
    logic [AW-1:0]  ram_wa, pos;
    t_mv            ram_wd, ram_rd;
    t_mv            cmp_a, cmp_b, cmp_diff;
    logic           cmp_gt;
    logic           chg_hi, sys_hi, steady;
    logic           rise_ge, rise_le, drop, gain;
    logic signed [MV_W+1:0] rise, change, step_s;

    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newer    <= RST_NEWER_BOARD;
            r_rise_mv  <= RST_RISE_MV;
            r_fall_mv  <= RST_FALL_MV;
            r_chg_min  <= RST_CHARGE_MIN;
            r_sys_load <= RST_SYS_LOAD;
            r_step     <= RST_VOLT_STEP;
            r_spread   <= RST_SPREAD_MAX;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.addr))
                CFG_NEWER_BOARD: r_newer    <= i_cfg.data[0];
                CFG_RISE_MV:     r_rise_mv  <= i_cfg.data;
                CFG_FALL_MV:     r_fall_mv  <= i_cfg.data;
                CFG_CHARGE_MIN:  r_chg_min  <= i_cfg.data;
                CFG_SYS_LOAD:    r_sys_load <= i_cfg.data;
                CFG_VOLT_STEP:   r_step     <= i_cfg.data;
                CFG_SPREAD_MAX:  r_spread   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pin <= i_in.charger_present;
            r_v   <= i_in.battery_mv;
            r_s   <= i_in.system_ma;
            r_c   <= i_in.charge_ma;
        end
    end

    cpd_ram #(
        .WIDTH (MV_W),
        .DEPTH (WINDOW_LEN)
    ) u_amps (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_wa),
        .i_wdata (ram_wd),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rd)
    );

    cpd_cmp u_cmp (
        .i_a    (cmp_a),
        .i_b    (cmp_b),
        .o_gt   (cmp_gt),
        .o_diff (cmp_diff)
    );

    assign pos     = (r_fill >= LAST) ? LAST : r_fill;
    assign chg_hi  = (r_c >= r_chg_min);
    assign sys_hi  = (r_s > r_sys_load);
    assign rise    = $signed({2'b00, r_v}) - $signed({2'b00, r_ref});
    assign rise_ge = (rise >= $signed({2'b00, r_rise_mv}));
    assign rise_le = (rise <= $signed({2'b00, r_fall_mv}));
    assign change  = $signed({2'b00, r_v}) - $signed({2'b00, r_volt0});
    assign step_s  = $signed({2'b00, r_step});
    assign drop    = (change < -step_s);
    assign gain    = (change > step_s);
    assign steady  = (cmp_diff < r_spread);

    always_comb begin
        n_state     = r_state;
        n_charging  = r_charging;
        n_plugged   = r_plugged;
        n_unplug    = r_unplug;
        n_hotplug   = r_hotplug;
        n_ref       = r_ref;
        n_volt0     = r_volt0;
        n_fill      = r_fill;
        n_wrap      = r_wrap;
        n_idx       = r_idx;
        n_mx        = r_mx;
        n_mn        = r_mn;
        ram_we      = 1'b0;
        ram_wa      = pos;
        ram_wd      = r_s;
        ram_re      = 1'b0;
        out_load    = 1'b0;
        cmp_a       = r_mn;
        cmp_b       = ram_rd;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_wrap = 1'b0;
                if (!r_pin) begin
                    n_ref      = r_v;
                    n_hotplug  = 1'b1;
                    n_charging = 1'b0;
                    n_plugged  = 1'b0;
                    n_unplug   = 1'b1;
                    n_state    = S_EMIT;
                end else begin
                    n_plugged = 1'b1;
                    n_state   = S_FINISH;
                    if (r_newer) begin
                        if (chg_hi) begin
                            n_charging = 1'b1;
                            n_unplug   = 1'b0;
                            n_hotplug  = 1'b0;
                        end
                        if (!chg_hi && !sys_hi) begin
                            n_charging = 1'b0;
                            n_unplug   = 1'b1;
                            n_hotplug  = 1'b0;
                        end
                        ram_we = 1'b1;
                        if (pos == '0) begin
                            n_volt0 = r_v;
                        end
                        if (pos == LAST) begin
                            n_wrap = 1'b1;
                            n_fill = AW'(1);
                            // trend check sees the hotplug flag after the current rules
                            if (!chg_hi && sys_hi && !n_hotplug) begin
                                n_idx   = '0;
                                n_mx    = r_s;
                                n_mn    = r_s;
                                n_state = S_READ;
                            end
                        end else begin
                            n_fill = pos + AW'(1);
                        end
                    end
                end
            end
            S_READ: begin
                ram_re  = 1'b1;
                n_state = S_MAX;
            end
            S_MAX: begin
                cmp_a = ram_rd;
                cmp_b = r_mx;
                if (cmp_gt) begin
                    n_mx = ram_rd;
                end
                n_state = S_MIN;
            end
            S_MIN: begin
                cmp_a = r_mn;
                cmp_b = ram_rd;
                if (cmp_gt) begin
                    n_mn = ram_rd;
                end
                if (r_idx == LAST_WALK) begin
                    n_state = S_TREND;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = S_READ;
                end
            end
            S_TREND: begin
                cmp_a = r_mx;
                cmp_b = r_mn;
                if (drop && steady && !r_unplug) begin
                    n_charging = 1'b0;
                    n_unplug   = 1'b1;
                end
                if (gain && steady && r_unplug) begin
                    n_charging = 1'b1;
                    n_unplug   = 1'b0;
                end
                n_state = S_FINISH;
            end
            S_FINISH: begin
                // confirm before clear, clear sees the flag as confirm left it
                if (rise_ge && r_hotplug) begin
                    n_hotplug  = 1'b0;
                    n_charging = 1'b1;
                end
                if (rise_le && n_hotplug) begin
                    n_charging = 1'b0;
                end
                // last entry carried into the next window
                if (r_wrap) begin
                    ram_we  = 1'b1;
                    ram_wa  = '0;
                    n_volt0 = r_v;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_charging  <= 1'b0;
            r_plugged   <= 1'b0;
            r_unplug    <= 1'b0;
            r_hotplug   <= 1'b0;
            r_ref       <= '0;
            r_volt0     <= '0;
            r_fill      <= '0;
            r_wrap      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_charging  <= n_charging;
            r_plugged   <= n_plugged;
            r_unplug    <= n_unplug;
            r_hotplug   <= n_hotplug;
            r_ref       <= n_ref;
            r_volt0     <= n_volt0;
            r_fill      <= n_fill;
            r_wrap      <= n_wrap;
            r_out_valid <= n_out_valid;
        end
        r_idx <= n_idx;
        r_mx  <= n_mx;
        r_mn  <= n_mn;
        if (out_load) begin
            r_out <= '{charging: r_charging, plugged: r_plugged,
                       unplug: r_unplug, hotplug: r_hotplug};
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.is_charging     = r_out.charging;
    assign o_out.charger_plugged = r_out.plugged;
    assign o_out.unplug_detected = r_out.unplug;
    assign o_out.hotplug_armed   = r_out.hotplug;

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in.ready)
        else $error("input taken again while a sample is in work");

    a_load_only_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(r_state == S_EMIT))
        else $error("result appeared outside the emit step");

    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= LAST)
        else $error("window fill beyond last position");

    a_pin_low_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && !r_pin) |=> (o_out.hotplug_armed && o_out.unplug_detected
                                  && !o_out.is_charging && !o_out.charger_plugged))
        else $error("low pin sample gave wrong flags");

endmodule
